/* rtl/med_pkg.sv */
// Shared types and constants for the motion envelope detector.
package med_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int THRESH_W   = 15;
  localparam int INTERVAL_W = 16;
  localparam int STATUS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int OUT_DEPTH  = 16;
  localparam int OUT_AW     = 4;
  localparam int OUT_CW     = 5;

  localparam logic [THRESH_W-1:0]   THRESH_RESET   = 15'd25;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd6;
  localparam logic [LEVEL_W-1:0]    LEVEL_MAX      = 15'h7fff;

  localparam logic [STATUS_W-1:0] ST_POWER  = 8'h10;
  localparam logic [STATUS_W-1:0] ST_BATLOW = 8'h08;
  localparam logic [STATUS_W-1:0] ST_TURN   = 8'h04;
  localparam logic [STATUS_W-1:0] ST_MOVE   = 8'h02;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_ACC  = 2'd0,
    CFG_THR_MAG  = 2'd1,
    CFG_INTERVAL = 2'd2
  } med_cfg_idx_e;

  typedef struct packed {
    logic [THRESH_W-1:0]   thr_acc;
    logic [THRESH_W-1:0]   thr_mag;
    logic [INTERVAL_W-1:0] interval;
  } med_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               bat;
    logic [LEVEL_W-1:0] level;
  } med_lvl_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_byte;
    logic                turning;
    logic                moving;
    logic [LEVEL_W-1:0]  acc_level;
    logic [LEVEL_W-1:0]  mag_level;
  } med_result_t;

endpackage

/* rtl/med_cdiv.sv */
// Two-stage divide by a constant, truncating toward zero, with a sideband tag.
module med_cdiv #(
  parameter int W       = 17,
  parameter int DIVISOR = 10,
  parameter int TW      = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [W-1:0]  value_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [W-1:0]  quot_o,
  output logic [TW-1:0] tag_o
);

  localparam logic [W:0]   Recip = (W+1)'((66'd1 << W) / DIVISOR);
  localparam logic [W-1:0] DivC  = W'(DIVISOR);

  logic          neg;
  logic [W-1:0]  mag;
  logic [2*W:0]  prod;
  logic          v1_q;
  logic          neg_q;
  logic [W-1:0]  mag_q;
  logic [W-1:0]  q0_q;
  logic [TW-1:0] tag1_q;
  logic [W-1:0]  back;
  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  quot_q;
  logic [TW-1:0] tag2_q;
  logic          v2_q;

  assign neg  = value_i[W-1];
  assign mag  = neg ? (W'(0) - value_i) : value_i;
  assign prod = mag * Recip;

  // estimate is exact or one short; one compare fixes it
  assign back = q0_q * DivC;
  assign rem  = mag_q - back;
  assign q    = q0_q + W'(rem >= DivC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg;
    mag_q  <= mag;
    q0_q   <= prod[2*W-1:W];
    tag1_q <= tag_i;
    quot_q <= neg_q ? (W'(0) - q) : q;
    tag2_q <= tag1_q;
  end

  assign valid_o = v2_q;
  assign quot_o  = quot_q;
  assign tag_o   = tag2_q;

endmodule

/* rtl/med_lane.sv */
// One sensor lane: decimation, raw window with running sum, deviation, envelope.
module med_lane #(
  parameter int RAW_WINDOW = 128,
  parameter int ENV_WINDOW = 10,
  parameter int DECIMATION = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              cmd_i,
  input  logic                              last_i,
  input  logic [med_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic                              bat_i,
  output med_pkg::med_lvl_t                 lvl_o
);
  import med_pkg::*;

  localparam int DSW = SAMPLE_W + 1 + $clog2(DECIMATION);
  localparam int WSW = SAMPLE_W + $clog2(RAW_WINDOW);
  localparam int RPW = $clog2(RAW_WINDOW);
  localparam int FCW = $clog2(RAW_WINDOW + 1);
  localparam int EPW = (ENV_WINDOW > 1) ? $clog2(ENV_WINDOW) : 1;
  localparam int ESW = LEVEL_W + $clog2(ENV_WINDOW);
  localparam int T1W = SAMPLE_W + 2;
  localparam int T2W = SAMPLE_W + 1;
  localparam logic signed [WSW-1:0] RawMul = WSW'(RAW_WINDOW);

  // decimation
  logic [DSW-1:0] dsum_q;
  logic [DSW-1:0] dsum_next;
  logic           d1_v;
  logic [DSW-1:0] d1_quot;
  logic [T1W-1:0] d1_tag;

  assign dsum_next = dsum_q + {{(DSW-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsum_q <= '0;
    end else if (accept_i && !cmd_i) begin
      dsum_q <= last_i ? '0 : dsum_next;
    end
  end

  med_cdiv #(.W(DSW), .DIVISOR(DECIMATION), .TW(T1W)) u_dec_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept_i && (cmd_i || last_i)),
    .value_i (dsum_next),
    .tag_i   ({cmd_i, bat_i, sample_i}),
    .valid_o (d1_v),
    .quot_o  (d1_quot),
    .tag_o   (d1_tag)
  );

  // raw window; entries older than the last preload read as the preload value
  logic [SAMPLE_W-1:0] avg;
  logic                pcmd;
  logic                pbat;
  logic [SAMPLE_W-1:0] raw;
  logic                wadv;
  logic [RPW-1:0]      wp_q;
  logic [RPW-1:0]      wp_d;
  logic [FCW-1:0]      fill_q;
  logic [SAMPLE_W-1:0] pre_q;
  logic [WSW-1:0]      wsum_q;
  logic [SAMPLE_W-1:0] rd_q;
  logic [SAMPLE_W-1:0] old;
  logic signed [WSW-1:0] raw_ext;
  logic [SAMPLE_W-1:0] raw_mem [RAW_WINDOW];
  logic                wv_q;
  logic                wbat_q;
  logic [SAMPLE_W-1:0] wavg_q;

  assign avg     = d1_quot[SAMPLE_W-1:0];
  assign pcmd    = d1_tag[T1W-1];
  assign pbat    = d1_tag[SAMPLE_W];
  assign raw     = d1_tag[SAMPLE_W-1:0];
  assign wadv    = d1_v && !pcmd;
  assign old     = (fill_q == FCW'(RAW_WINDOW)) ? rd_q : pre_q;
  assign raw_ext = {{(WSW-SAMPLE_W){raw[SAMPLE_W-1]}}, raw};

  always_comb begin
    wp_d = wp_q;
    if (wadv) begin
      wp_d = (wp_q == RPW'(RAW_WINDOW - 1)) ? '0 : wp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wadv) begin
      raw_mem[wp_q] <= avg;
    end
    rd_q <= raw_mem[wp_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      pre_q  <= '0;
      wsum_q <= '0;
      wv_q   <= 1'b0;
    end else begin
      wv_q <= wadv;
      if (d1_v && pcmd) begin
        pre_q  <= raw;
        fill_q <= '0;
        wsum_q <= raw_ext * RawMul;
      end else if (wadv) begin
        wsum_q <= wsum_q + {{(WSW-SAMPLE_W){avg[SAMPLE_W-1]}}, avg}
                         - {{(WSW-SAMPLE_W){old[SAMPLE_W-1]}}, old};
        if (fill_q != FCW'(RAW_WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
        wp_q <= wp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wavg_q <= avg;
    wbat_q <= pbat;
  end

  // window mean and deviation
  logic                d2_v;
  logic [WSW-1:0]      d2_quot;
  logic [T2W-1:0]      d2_tag;
  logic [SAMPLE_W-1:0] mean;
  logic [SAMPLE_W-1:0] davg;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   dmag;
  logic [LEVEL_W-1:0]  dev;
  logic                dvv_q;
  logic                dvbat_q;
  logic [LEVEL_W-1:0]  dv_q;

  med_cdiv #(.W(WSW), .DIVISOR(RAW_WINDOW), .TW(T2W)) u_win_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (wv_q),
    .value_i (wsum_q),
    .tag_i   ({wbat_q, wavg_q}),
    .valid_o (d2_v),
    .quot_o  (d2_quot),
    .tag_o   (d2_tag)
  );

  assign mean = d2_quot[SAMPLE_W-1:0];
  assign davg = d2_tag[SAMPLE_W-1:0];
  assign diff = {davg[SAMPLE_W-1], davg} - {mean[SAMPLE_W-1], mean};
  assign dmag = diff[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - diff) : diff;
  assign dev  = (dmag > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : dmag[LEVEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q <= 1'b0;
    end else begin
      dvv_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q    <= dev;
    dvbat_q <= d2_tag[T2W-1];
  end

  // envelope store
  logic [EPW-1:0]      ep_q;
  logic [EPW-1:0]      ep_d;
  logic [ENV_WINDOW-1:0] evld_q;
  logic [LEVEL_W-1:0]  env_mem [ENV_WINDOW];
  logic [LEVEL_W-1:0]  erd_q;
  logic [LEVEL_W-1:0]  eold;
  logic [ESW-1:0]      esum_q;
  logic                ev_q;
  logic                ebat_q;
  logic                d3_v;
  logic [ESW:0]        d3_quot;
  logic                d3_bat;

  assign eold = evld_q[ep_q] ? erd_q : '0;

  always_comb begin
    ep_d = ep_q;
    if (dvv_q) begin
      ep_d = (ep_q == EPW'(ENV_WINDOW - 1)) ? '0 : ep_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dvv_q) begin
      env_mem[ep_q] <= dv_q;
    end
    if (dvv_q && ep_d == ep_q) begin
      erd_q <= dv_q;
    end else begin
      erd_q <= env_mem[ep_d];
    end
    ebat_q <= dvbat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_q   <= '0;
      evld_q <= '0;
      esum_q <= '0;
      ev_q   <= 1'b0;
    end else begin
      ev_q <= dvv_q;
      if (dvv_q) begin
        evld_q[ep_q] <= 1'b1;
        esum_q       <= esum_q + ESW'(dv_q) - ESW'(eold);
        ep_q         <= ep_d;
      end
    end
  end

  med_cdiv #(.W(ESW + 1), .DIVISOR(ENV_WINDOW), .TW(1)) u_env_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ev_q),
    .value_i ({1'b0, esum_q}),
    .tag_i   (ebat_q),
    .valid_o (d3_v),
    .quot_o  (d3_quot),
    .tag_o   (d3_bat)
  );

  assign lvl_o.valid = d3_v;
  assign lvl_o.bat   = d3_bat;
  assign lvl_o.level = d3_quot[LEVEL_W-1:0];

endmodule

/* rtl/med_merge.sv */
// Merges the two lanes: report interval, threshold compare, status and output queue.
module med_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  med_pkg::med_cfg_t     cfg_i,
  input  logic                  reserve_i,
  output logic                  ready_o,
  input  med_pkg::med_lvl_t     acc_i,
  input  med_pkg::med_lvl_t     mag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output med_pkg::med_result_t  res_o
);
  import med_pkg::*;

  logic [INTERVAL_W-1:0] rc_q;
  logic [INTERVAL_W:0]   rc_inc;
  logic                  fire;
  logic                  push;
  logic                  pop;
  logic                  drop;
  logic                  turning;
  logic                  moving;
  med_result_t           res;
  med_result_t           fifo_q [OUT_DEPTH];
  logic [OUT_AW-1:0]     wr_q;
  logic [OUT_AW-1:0]     rd_q;
  logic [OUT_CW-1:0]     cnt_q;
  logic [OUT_CW-1:0]     resv_q;

  assign rc_inc  = {1'b0, rc_q} + 1'b1;
  assign fire    = rc_inc >= {1'b0, cfg_i.interval};
  assign push    = acc_i.valid && fire;
  assign drop    = acc_i.valid && !fire;
  assign pop     = out_valid_o && out_ready_i;
  assign turning = mag_i.level > cfg_i.thr_mag;
  assign moving  = acc_i.level > cfg_i.thr_acc;

  always_comb begin
    res.status_byte = ST_POWER;
    if (turning) begin
      res.status_byte = res.status_byte | ST_TURN | ST_MOVE;
    end
    if (acc_i.bat) begin
      res.status_byte = res.status_byte | ST_BATLOW;
    end
    res.turning   = turning;
    res.moving    = moving;
    res.acc_level = acc_i.level;
    res.mag_level = mag_i.level;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res;
    end
  end

  // slots are booked at input so a queued report always has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q   <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      resv_q <= '0;
    end else begin
      if (acc_i.valid) begin
        rc_q <= fire ? '0 : rc_inc[INTERVAL_W-1:0];
      end
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q  <= cnt_q + OUT_CW'(push) - OUT_CW'(pop);
      resv_q <= resv_q + OUT_CW'(reserve_i) - OUT_CW'(drop) - OUT_CW'(pop);
    end
  end

  assign ready_o     = resv_q < OUT_CW'(OUT_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign res_o       = fifo_q[rd_q];

endmodule

/* rtl/motion_envelope_detector.sv */
// Top level: motion envelope detector with accelerometer and magnetometer lanes.
//
// Takes one word per clock while ready is high. Every DECIMATION ordinary
// words make one decimated sample per lane; each lane runs it through a
// constant divider, the raw window (one memory read and one write per
// sample), a second divider for the window mean, the deviation clamp, the
// envelope store and a third divider before its report is queued. A preload
// word marks the whole raw window as holding its value, with no fill sweep.
// Reports wait in a 16-word output queue; ready drops only while 16 decimated
// samples are in flight or queued, so with the output taken every cycle the
// input never stalls.
module motion_envelope_detector #(
  parameter int RAW_WINDOW = 128,
  parameter int ENV_WINDOW = 10,
  parameter int DECIMATION = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [med_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [med_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [med_pkg::SAMPLE_W-1:0]        acc_sample_i,
  input  logic [med_pkg::SAMPLE_W-1:0]        mag_sample_i,
  input  logic                                battery_low_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [med_pkg::STATUS_W-1:0]        status_byte_o,
  output logic                                turning_o,
  output logic                                moving_o,
  output logic [med_pkg::LEVEL_W-1:0]         acc_level_o,
  output logic [med_pkg::LEVEL_W-1:0]         mag_level_o
);
  import med_pkg::*;

  localparam int DCW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  med_cfg_t    cfg_q;
  logic [DCW-1:0] dc_q;
  logic        accept;
  logic        last;
  logic        ready;
  med_lvl_t    acc_lvl;
  med_lvl_t    mag_lvl;
  med_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr_acc  <= THRESH_RESET;
      cfg_q.thr_mag  <= THRESH_RESET;
      cfg_q.interval <= INTERVAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THR_ACC:  cfg_q.thr_acc  <= cfg_data_i[THRESH_W-1:0];
        CFG_THR_MAG:  cfg_q.thr_mag  <= cfg_data_i[THRESH_W-1:0];
        CFG_INTERVAL: cfg_q.interval <= cfg_data_i[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && ready;
  assign last   = dc_q == DCW'(DECIMATION - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= '0;
    end else if (accept && !cmd_i) begin
      dc_q <= last ? '0 : dc_q + 1'b1;
    end
  end

  med_lane #(
    .RAW_WINDOW (RAW_WINDOW),
    .ENV_WINDOW (ENV_WINDOW),
    .DECIMATION (DECIMATION)
  ) u_acc_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .last_i   (last),
    .sample_i (acc_sample_i),
    .bat_i    (battery_low_i),
    .lvl_o    (acc_lvl)
  );

  med_lane #(
    .RAW_WINDOW (RAW_WINDOW),
    .ENV_WINDOW (ENV_WINDOW),
    .DECIMATION (DECIMATION)
  ) u_mag_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .last_i   (last),
    .sample_i (mag_sample_i),
    .bat_i    (battery_low_i),
    .lvl_o    (mag_lvl)
  );

  med_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .reserve_i   (accept && !cmd_i && last),
    .ready_o     (ready),
    .acc_i       (acc_lvl),
    .mag_i       (mag_lvl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign in_ready_o    = ready;
  assign status_byte_o = res.status_byte;
  assign turning_o     = res.turning;
  assign moving_o      = res.moving;
  assign acc_level_o   = res.acc_level;
  assign mag_level_o   = res.mag_level;

endmodule

/* tb/tb.sv */
// Self-checking testbench for motion_envelope_detector: directed and random words against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import med_pkg::*;

  localparam int RAW_WINDOW  = 128;
  localparam int ENV_WINDOW  = 10;
  localparam int DECIMATION  = 10;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] acc;
    logic [SAMPLE_W-1:0] mag;
    logic                bat;
  } sensor_word_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  cmd_i         = 1'b0;
  logic [SAMPLE_W-1:0]   acc_sample_i  = '0;
  logic [SAMPLE_W-1:0]   mag_sample_i  = '0;
  logic                  battery_low_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [STATUS_W-1:0]   status_byte_o;
  logic                  turning_o;
  logic                  moving_o;
  logic [LEVEL_W-1:0]    acc_level_o;
  logic [LEVEL_W-1:0]    mag_level_o;

  motion_envelope_detector u_top (.*);

  sensor_word_t word_q[$];
  med_result_t  report_q[$];
  sensor_word_t cur_word;
  int           mismatch_cnt = 0;
  int           cycle_cnt    = 0;
  int           send_gap     = 0;
  int           recv_gap     = 0;
  bit           send_idle    = 1'b1;
  bit           recv_idle    = 1'b1;
  bit           hold_req     = 1'b0;
  logic         hold_off     = 1'b0;

  // predictor state
  int lim_acc      = THRESH_RESET;
  int lim_mag      = THRESH_RESET;
  int report_every = INTERVAL_RESET;
  int decim_n, acc_dsum, mag_dsum;
  int acc_win[RAW_WINDOW];
  int mag_win[RAW_WINDOW];
  int win_ptr, acc_wsum, mag_wsum;
  int acc_env[ENV_WINDOW];
  int mag_env[ENV_WINDOW];
  int env_ptr, acc_esum, mag_esum, report_n;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int env_dev(input int avg, input int wsum);
    int d;
    d = avg - wsum / RAW_WINDOW;
    if (d < 0) d = -d;
    if (d > int'(LEVEL_MAX)) d = int'(LEVEL_MAX);
    return d;
  endfunction

  function automatic void detector_step(input sensor_word_t w);
    int          acc, mag, acc_avg, mag_avg, acc_dev, mag_dev, acc_lvl, mag_lvl, i;
    med_result_t r;
    acc = int'($signed(w.acc));
    mag = int'($signed(w.mag));
    if (w.cmd) begin
      for (i = 0; i < RAW_WINDOW; i++) begin
        acc_win[i] = acc;
        mag_win[i] = mag;
      end
      acc_wsum = acc * RAW_WINDOW;
      mag_wsum = mag * RAW_WINDOW;
      return;
    end
    acc_dsum += acc;
    mag_dsum += mag;
    decim_n++;
    if (decim_n < DECIMATION) return;
    acc_avg  = acc_dsum / DECIMATION;
    mag_avg  = mag_dsum / DECIMATION;
    acc_dsum = 0;
    mag_dsum = 0;
    decim_n  = 0;
    acc_wsum += acc_avg - acc_win[win_ptr];
    mag_wsum += mag_avg - mag_win[win_ptr];
    acc_win[win_ptr] = acc_avg;
    mag_win[win_ptr] = mag_avg;
    win_ptr = (win_ptr + 1) % RAW_WINDOW;
    acc_dev = env_dev(acc_avg, acc_wsum);
    mag_dev = env_dev(mag_avg, mag_wsum);
    acc_esum += acc_dev - acc_env[env_ptr];
    mag_esum += mag_dev - mag_env[env_ptr];
    acc_env[env_ptr] = acc_dev;
    mag_env[env_ptr] = mag_dev;
    env_ptr = (env_ptr + 1) % ENV_WINDOW;
    acc_lvl = acc_esum / ENV_WINDOW;
    mag_lvl = mag_esum / ENV_WINDOW;
    report_n++;
    if (report_n < report_every) return;
    report_n = 0;
    r.turning     = (mag_lvl > lim_mag);
    r.moving      = (acc_lvl > lim_acc);
    r.status_byte = ST_POWER | (r.turning ? (ST_TURN | ST_MOVE) : '0) |
                    (w.bat ? ST_BATLOW : '0);
    r.acc_level   = acc_lvl[LEVEL_W-1:0];
    r.mag_level   = mag_lvl[LEVEL_W-1:0];
    report_q.push_back(r);
  endfunction

  function automatic sensor_word_t make_word(input logic cmd, input logic [SAMPLE_W-1:0] acc,
                                             input logic [SAMPLE_W-1:0] mag, input logic bat);
    sensor_word_t w;
    w.cmd = cmd;
    w.acc = acc;
    w.mag = mag;
    w.bat = bat;
    return w;
  endfunction

  // spread of zero means full-range samples
  function automatic sensor_word_t random_word(input int spread, input int acc_dc,
                                               input int mag_dc);
    sensor_word_t w;
    w.cmd = ($urandom_range(0, 49) == 0);
    w.bat = 1'($urandom);
    if (spread == 0) begin
      w.acc = 16'($urandom);
      w.mag = 16'($urandom);
    end else begin
      w.acc = 16'(acc_dc + int'($urandom_range(0, 2 * spread)) - spread);
      w.mag = 16'(mag_dc + int'($urandom_range(0, 2 * spread)) - spread);
    end
    return w;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) detector_step(cur_word);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (send_idle && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          in_valid_i    <= 1'b1;
          cmd_i         <= cur_word.cmd;
          acc_sample_i  <= cur_word.acc;
          mag_sample_i  <= cur_word.mag;
          battery_low_i <= cur_word.bat;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    med_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (report_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected report status=%h turn=%b move=%b acc=%0d mag=%0d",
                     $realtime, status_byte_o, turning_o, moving_o, acc_level_o, mag_level_o);
        end else begin
          want = report_q.pop_front();
          if (status_byte_o !== want.status_byte || turning_o !== want.turning ||
              moving_o !== want.moving || acc_level_o !== want.acc_level ||
              mag_level_o !== want.mag_level) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: report mismatch exp status=%h turn=%b move=%b acc=%0d mag=%0d",
                        " got status=%h turn=%b move=%b acc=%0d mag=%0d"},
                       $realtime, want.status_byte, want.turning, want.moving,
                       want.acc_level, want.mag_level, status_byte_o, turning_o, moving_o,
                       acc_level_o, mag_level_o);
          end
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_THR_ACC:  lim_acc = int'(data[THRESH_W-1:0]);
      CFG_THR_MAG:  lim_mag = int'(data[THRESH_W-1:0]);
      CFG_INTERVAL: report_every = int'(data[INTERVAL_W-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (word_q.size() != 0 || in_valid_i || report_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic run_phase(input int n, input int spread);
    int acc_dc, mag_dc, i;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        acc_dc = int'($urandom_range(0, 40000)) - 20000;
        mag_dc = int'($urandom_range(0, 40000)) - 20000;
      end
      word_q.push_back(random_word(spread, acc_dc, mag_dc));
    end
    settle();
  endtask

  task automatic random_thresholds(input int top);
    write_reg(CFG_THR_ACC, {1'($urandom), 15'($urandom_range(0, top))});
    write_reg(CFG_THR_MAG, {1'($urandom), 15'($urandom_range(0, top))});
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // preload at the extremes, then clamp the deviation in both directions
    word_q.push_back(make_word(1'b1, 16'h8000, 16'h7fff, 1'b0));
    for (i = 0; i < 10; i++)
      word_q.push_back(make_word(1'b0, 16'h7fff, 16'h8000, 1'(i)));
    // negative averages truncate toward zero
    word_q.push_back(make_word(1'b1, 16'h0000, 16'h0000, 1'b1));
    for (i = 0; i < 10; i++)
      word_q.push_back(make_word(1'b0, 16'(-3 * (i + 1)), 16'(5 * i - 13), 1'(i + 1)));
    run_phase(60, 40);

    write_reg(CFG_THR_ACC, 16'h0000);
    write_reg(CFG_THR_MAG, 16'hffff);
    write_reg(CFG_INTERVAL, 16'd1);
    run_phase(100, 0);

    write_reg(CFG_THR_ACC, 16'h7fff);
    write_reg(CFG_THR_MAG, 16'h0000);
    write_reg(CFG_INTERVAL, 16'd0);
    run_phase(120, 60);

    // output held off while words keep coming: the block must fill and stall
    random_thresholds(60);
    write_reg(CFG_INTERVAL, 16'd1);
    send_idle = 1'b0;
    hold_req  = 1'b1;
    run_phase(250, 100);
    send_idle = 1'b1;

    random_thresholds(32767);
    write_reg(CFG_INTERVAL, 16'hffff);
    run_phase(100, 0);
    // interval lowered below the running count
    write_reg(CFG_INTERVAL, 16'd3);
    run_phase(150, 30);

    write_reg(CFG_SPARE, 16'($urandom));
    random_thresholds(40);
    write_reg(CFG_INTERVAL, 16'($urandom_range(1, 4)));
    run_phase(150, 20);

    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(CFG_INTERVAL, 16'd2);
    run_phase(100, 0);

    if (mismatch_cnt == 0 && report_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
